@@ rtl/rsa_pkg.sv @@
// ----------------------------------------------------------------------------
// rsa_pkg
// Shared types and constants for the region slot allocator: default sizes,
// result status codes, and the command/status bundles between the
// controller and the datapath.
// ----------------------------------------------------------------------------
package rsa_pkg;

  localparam int unsigned DefSlotsPerBuffer = 256;
  localparam int unsigned DefMaxBuffers     = 16;
  localparam int unsigned DefMaxRegions     = 64;

  // Fixed port widths
  localparam int unsigned BufIdxW = 4;
  localparam int unsigned SlotW   = 8;
  localparam int unsigned StatusW = 2;

  typedef enum logic [StatusW-1:0] {
    ST_OK        = 2'd0,
    ST_NO_BUFFER = 2'd1,
    ST_LIST_FULL = 2'd2
  } status_e;

  // Controller -> datapath
  typedef struct packed {
    logic accept;      // latch request fields
    logic acq_fail;    // acquire, no buffer left
    logic acq_open;    // acquire from a freshly opened buffer
    logic acq_read;    // read last region
    logic acq_take;    // take first slot of region just read
    logic rel_skip;    // release out of range, ignored
    logic scan_start;  // reset scan pointer
    logic scan_step;   // issue next scan read
    logic rel_grow;    // extend the matching region
    logic rel_append;  // append a one-slot region
    logic rel_full;    // release dropped, list full
    logic out_load;    // move result into output register
  } rsa_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic req_release;
    logic count_zero;
    logic no_buffer;
    logic rel_bad;
    logic scan_more;
    logic rd_pend;
    logic hit;
    logic list_full;
    logic out_free;
  } rsa_stat_t;

endpackage

@@ rtl/rsa_ctrl.sv @@
// ----------------------------------------------------------------------------
// rsa_ctrl
// Sequencing state machine for the region slot allocator.
// ----------------------------------------------------------------------------
module rsa_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  rsa_pkg::rsa_stat_t stat_i,
  output rsa_pkg::rsa_cmd_t  cmd_o
);

  typedef enum logic [5:0] {
    S_IDLE     = 6'b000001,
    S_ACQ      = 6'b000010,
    S_ACQ_TAKE = 6'b000100,
    S_REL      = 6'b001000,
    S_SCAN     = 6'b010000,
    S_DONE     = 6'b100000
  } state_e;

  state_e state_q, state_d;

  assign in_stall_o = (state_q != S_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d      = stat_i.req_release ? S_REL : S_ACQ;
        end
      end
      S_ACQ: begin
        if (!stat_i.count_zero) begin
          cmd_o.acq_read = 1'b1;
          state_d        = S_ACQ_TAKE;
        end else if (stat_i.no_buffer) begin
          cmd_o.acq_fail = 1'b1;
          state_d        = S_DONE;
        end else begin
          cmd_o.acq_open = 1'b1;
          state_d        = S_DONE;
        end
      end
      S_ACQ_TAKE: begin
        cmd_o.acq_take = 1'b1;
        state_d        = S_DONE;
      end
      S_REL: begin
        if (stat_i.rel_bad) begin
          cmd_o.rel_skip = 1'b1;
          state_d        = S_DONE;
        end else begin
          cmd_o.scan_start = 1'b1;
          state_d          = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat_i.rd_pend && stat_i.hit) begin
          cmd_o.rel_grow = 1'b1;
          state_d        = S_DONE;
        end else if (stat_i.scan_more || stat_i.rd_pend) begin
          cmd_o.scan_step = 1'b1;
        end else if (stat_i.list_full) begin
          cmd_o.rel_full = 1'b1;
          state_d        = S_DONE;
        end else begin
          cmd_o.rel_append = 1'b1;
          state_d          = S_DONE;
        end
      end
      S_DONE: begin
        if (stat_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

@@ rtl/rsa_datapath.sv @@
// ----------------------------------------------------------------------------
// rsa_datapath
// Region table memory, counters, request/result registers and the output
// register of the region slot allocator.
// ----------------------------------------------------------------------------
module rsa_datapath #(
  parameter int unsigned SLOTS_PER_BUFFER = rsa_pkg::DefSlotsPerBuffer,
  parameter int unsigned MAX_BUFFERS      = rsa_pkg::DefMaxBuffers,
  parameter int unsigned MAX_REGIONS      = rsa_pkg::DefMaxRegions
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        action_i,
  input  logic [rsa_pkg::BufIdxW-1:0] buffer_index_i,
  input  logic [rsa_pkg::SlotW-1:0]   slot_index_i,
  input  logic                        out_stall_i,
  output logic                        out_valid_o,
  output logic [rsa_pkg::SlotW-1:0]   given_slot_o,
  output logic [rsa_pkg::BufIdxW-1:0] given_buffer_o,
  output logic [rsa_pkg::StatusW-1:0] status_o,
  input  rsa_pkg::rsa_cmd_t           cmd_i,
  output rsa_pkg::rsa_stat_t          stat_o
);

  localparam int unsigned OffW   = $clog2(SLOTS_PER_BUFFER);
  localparam int unsigned CntW   = $clog2(SLOTS_PER_BUFFER + 1);
  localparam int unsigned BufW   = (MAX_BUFFERS > 1) ? $clog2(MAX_BUFFERS) : 1;
  localparam int unsigned OpnW   = $clog2(MAX_BUFFERS + 1);
  localparam int unsigned IdxW   = $clog2(MAX_REGIONS);
  localparam int unsigned RcW    = $clog2(MAX_REGIONS + 1);
  localparam int unsigned EntW   = BufW + OffW + CntW;
  localparam int unsigned MaxA   = (CntW > OpnW) ? CntW : OpnW;
  localparam int unsigned MaxB   = (MaxA > rsa_pkg::SlotW + 1) ? MaxA : rsa_pkg::SlotW + 1;
  localparam int unsigned CmpW   = MaxB + 1;

  // region table
  logic [EntW-1:0] mem_q [MAX_REGIONS];
  logic [EntW-1:0] rd_q;
  logic            rd_en;
  logic [IdxW-1:0] rd_addr;
  logic            wr_en;
  logic [IdxW-1:0] wr_addr;
  logic [EntW-1:0] wr_data;

  logic [BufW-1:0] rd_buf;
  logic [OffW-1:0] rd_off;
  logic [CntW-1:0] rd_cnt;

  // bookkeeping
  logic [RcW-1:0]  count_q, count_d;
  logic [OpnW-1:0] opened_q, opened_d;
  logic [RcW-1:0]  issue_q, issue_d;
  logic            pend_q, pend_d;
  logic [IdxW-1:0] chk_q;

  // request
  logic                        req_rel_q;
  logic [rsa_pkg::BufIdxW-1:0] req_buf_q;
  logic [rsa_pkg::SlotW-1:0]   req_slot_q;

  // result and output register
  logic [rsa_pkg::SlotW-1:0]   res_slot_q, res_slot_d;
  logic [rsa_pkg::BufIdxW-1:0] res_buf_q, res_buf_d;
  rsa_pkg::status_e            res_st_q, res_st_d;
  logic                        out_valid_q, out_valid_d;
  logic [rsa_pkg::SlotW-1:0]   out_slot_q;
  logic [rsa_pkg::BufIdxW-1:0] out_buf_q;
  rsa_pkg::status_e            out_st_q;

  logic [CmpW-1:0] x_slot, x_buf, x_rbuf, x_off, x_end;
  logic            hit_down, hit_up;
  logic [RcW-1:0]  last_idx;

  assign {rd_buf, rd_off, rd_cnt} = rd_q;

  assign x_slot   = CmpW'(req_slot_q);
  assign x_buf    = CmpW'(req_buf_q);
  assign x_rbuf   = CmpW'(rd_buf);
  assign x_off    = CmpW'(rd_off);
  assign x_end    = CmpW'(rd_off) + CmpW'(rd_cnt);
  assign hit_down = (x_rbuf == x_buf) && (x_off == x_slot + CmpW'(1));
  assign hit_up   = (x_rbuf == x_buf) && (x_slot == x_end);
  assign last_idx = count_q - RcW'(1);

  assign stat_o.req_release = action_i;
  assign stat_o.count_zero  = (count_q == '0);
  assign stat_o.no_buffer   = (opened_q == OpnW'(MAX_BUFFERS));
  assign stat_o.rel_bad     = (x_slot >= CmpW'(SLOTS_PER_BUFFER)) ||
                              (x_buf >= CmpW'(opened_q));
  assign stat_o.scan_more   = (issue_q < count_q);
  assign stat_o.rd_pend     = pend_q;
  assign stat_o.hit         = hit_down || hit_up;
  assign stat_o.list_full   = (count_q == RcW'(MAX_REGIONS));
  assign stat_o.out_free    = !out_valid_q || !out_stall_i;

  // memory ports
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = issue_q[IdxW-1:0];
    if (cmd_i.acq_read) begin
      rd_en   = 1'b1;
      rd_addr = last_idx[IdxW-1:0];
    end else if (cmd_i.scan_step && stat_o.scan_more) begin
      rd_en = 1'b1;
    end
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_addr = chk_q;
    wr_data = rd_q;
    if (cmd_i.acq_open) begin
      wr_en   = 1'b1;
      wr_addr = '0;
      wr_data = {opened_q[BufW-1:0], OffW'(1), CntW'(SLOTS_PER_BUFFER - 1)};
    end else if (cmd_i.acq_take) begin
      wr_en   = 1'b1;
      wr_data = {rd_buf, rd_off + OffW'(1), rd_cnt - CntW'(1)};
    end else if (cmd_i.rel_grow) begin
      wr_en = 1'b1;
      if (hit_down) begin
        wr_data = {rd_buf, x_slot[OffW-1:0], rd_cnt + CntW'(1)};
      end else begin
        wr_data = {rd_buf, rd_off, rd_cnt + CntW'(1)};
      end
    end else if (cmd_i.rel_append) begin
      wr_en   = 1'b1;
      wr_addr = count_q[IdxW-1:0];
      wr_data = {x_buf[BufW-1:0], x_slot[OffW-1:0], CntW'(1)};
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem_q[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q  <= mem_q[rd_addr];
      chk_q <= rd_addr;
    end
  end

  // counters
  always_comb begin
    count_d  = count_q;
    opened_d = opened_q;
    issue_d  = issue_q;
    pend_d   = pend_q;
    if (cmd_i.acq_open) begin
      count_d  = RcW'(1);
      opened_d = opened_q + OpnW'(1);
    end
    if (cmd_i.acq_take && (rd_cnt == CntW'(1))) begin
      count_d = last_idx;
    end
    if (cmd_i.rel_append) begin
      count_d = count_q + RcW'(1);
    end
    if (cmd_i.scan_start) begin
      issue_d = '0;
      pend_d  = 1'b0;
    end
    if (cmd_i.scan_step) begin
      pend_d = stat_o.scan_more;
      if (stat_o.scan_more) begin
        issue_d = issue_q + RcW'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q  <= '0;
      opened_q <= '0;
      issue_q  <= '0;
      pend_q   <= 1'b0;
    end else begin
      count_q  <= count_d;
      opened_q <= opened_d;
      issue_q  <= issue_d;
      pend_q   <= pend_d;
    end
  end

  // request capture
  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      req_rel_q  <= action_i;
      req_buf_q  <= buffer_index_i;
      req_slot_q <= slot_index_i;
    end
  end

  // result
  always_comb begin
    res_slot_d = res_slot_q;
    res_buf_d  = res_buf_q;
    res_st_d   = res_st_q;
    if (cmd_i.acq_open) begin
      res_slot_d = '0;
      res_buf_d  = rsa_pkg::BufIdxW'(opened_q);
      res_st_d   = rsa_pkg::ST_OK;
    end else if (cmd_i.acq_take) begin
      res_slot_d = rsa_pkg::SlotW'(rd_off);
      res_buf_d  = rsa_pkg::BufIdxW'(rd_buf);
      res_st_d   = rsa_pkg::ST_OK;
    end else if (cmd_i.acq_fail) begin
      res_slot_d = '0;
      res_buf_d  = '0;
      res_st_d   = rsa_pkg::ST_NO_BUFFER;
    end else if (cmd_i.rel_full) begin
      res_slot_d = '0;
      res_buf_d  = '0;
      res_st_d   = rsa_pkg::ST_LIST_FULL;
    end else if (cmd_i.rel_skip || cmd_i.rel_grow || cmd_i.rel_append) begin
      res_slot_d = '0;
      res_buf_d  = '0;
      res_st_d   = rsa_pkg::ST_OK;
    end
  end

  always_ff @(posedge clk_i) begin
    res_slot_q <= res_slot_d;
    res_buf_q  <= res_buf_d;
    res_st_q   <= res_st_d;
    if (cmd_i.out_load) begin
      out_slot_q <= req_rel_q ? '0 : res_slot_q;
      out_buf_q  <= req_rel_q ? '0 : res_buf_q;
      out_st_q   <= res_st_q;
    end
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_i.out_load) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign given_slot_o   = out_slot_q;
  assign given_buffer_o = out_buf_q;
  assign status_o       = out_st_q;

endmodule

@@ rtl/region_slot_allocator_top.sv @@
// ----------------------------------------------------------------------------
// region_slot_allocator_top
// Slot allocator over fixed-size buffers, free space held as a region list.
// ----------------------------------------------------------------------------
// Hands out and takes back slots in buffers of SLOTS_PER_BUFFER slots, up to
// MAX_BUFFERS buffers. Free space is a list of up to MAX_REGIONS regions
// (buffer, start offset, count) held in a single-port-read RAM. An acquire
// (action 0) takes the first slot of the last region, opening a new buffer
// when the list is empty; status 1 means no buffer is left. A release
// (action 1) grows the first region of the same buffer adjacent to the slot,
// or appends a one-slot region; status 2 means the list was full and the slot
// is dropped. Out-of-range releases are ignored with status 0. One request is
// processed at a time. An acquire that opens a new buffer or finds none left
// does without a table read, and a release scan stops at the first match. The
// scan reads one table entry per cycle through the RAM read port. The next
// request is taken the cycle after the result is loaded. The result sits in
// an output register, so a new request may be taken while a result still
// waits to be transferred; the following result then waits until that
// register is free. The table needs no clearing after reset.
// ----------------------------------------------------------------------------
module region_slot_allocator_top #(
  parameter int unsigned SLOTS_PER_BUFFER = rsa_pkg::DefSlotsPerBuffer,
  parameter int unsigned MAX_BUFFERS      = rsa_pkg::DefMaxBuffers,
  parameter int unsigned MAX_REGIONS      = rsa_pkg::DefMaxRegions
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  // request channel
  input  logic                        in_valid_i,
  output logic                        in_stall_o,
  input  logic                        action_i,
  input  logic [rsa_pkg::BufIdxW-1:0] buffer_index_i,
  input  logic [rsa_pkg::SlotW-1:0]   slot_index_i,
  // result channel
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output logic [rsa_pkg::SlotW-1:0]   given_slot_o,
  output logic [rsa_pkg::BufIdxW-1:0] given_buffer_o,
  output logic [rsa_pkg::StatusW-1:0] status_o
);

  rsa_pkg::rsa_cmd_t  cmd;
  rsa_pkg::rsa_stat_t stat;

  // sequencer
  rsa_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .stat_i     (stat),
    .cmd_o      (cmd)
  );

  // region table, counters and result register
  rsa_datapath #(
    .SLOTS_PER_BUFFER (SLOTS_PER_BUFFER),
    .MAX_BUFFERS      (MAX_BUFFERS),
    .MAX_REGIONS      (MAX_REGIONS)
  ) u_datapath (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .action_i       (action_i),
    .buffer_index_i (buffer_index_i),
    .slot_index_i   (slot_index_i),
    .out_stall_i    (out_stall_i),
    .out_valid_o    (out_valid_o),
    .given_slot_o   (given_slot_o),
    .given_buffer_o (given_buffer_o),
    .status_o       (status_o),
    .cmd_i          (cmd),
    .stat_o         (stat)
  );

endmodule
